// ===== rtl/ihc_pkg.sv =====
// Shared types and constants for the IPv4 receive header check.
package ihc_pkg;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT        = 3'd0,
      VERDICT_VERSION       = 3'd1,
      VERDICT_HEADER_LENGTH = 3'd2,
      VERDICT_TTL           = 3'd3,
      VERDICT_CHECKSUM      = 3'd4,
      VERDICT_DESTINATION   = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_of_packet;
   } item_type;

   typedef struct packed {
      logic        valid;
      verdict_type verdict;
   } result_type;

   localparam logic [3:0]  IP_VERSION    = 4'h4;
   localparam logic [3:0]  MIN_IHL       = 4'h5;
   localparam logic [4:0]  CSUM_WORD     = 5'd5;
   localparam logic [5:0]  TTL_POS       = 6'd8;
   localparam logic [5:0]  CSUM_HI_POS   = 6'd10;
   localparam logic [5:0]  CSUM_LO_POS   = 6'd11;
   localparam logic [5:0]  DEST_FIRST    = 6'd16;
   localparam logic [5:0]  DEST_LAST     = 6'd19;
   localparam logic [31:0] BROADCAST     = 32'hffff_ffff;
   localparam logic        REG_LOCAL_ADDRESS = 1'b0;

endpackage

// ===== rtl/ihc_csr.sv =====
// Configuration register file: local address behind an APB-style port.
module ihc_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [31:0] local_address
);

   logic [31:0] local_address_ff;
   logic [31:0] local_address_in;
   logic        write_hit;

   assign csr_pready = 1'b1;
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == ihc_pkg::REG_LOCAL_ADDRESS);

   always_comb begin
      local_address_in = write_hit ? csr_pwdata : local_address_ff;
      csr_prdata = (csr_paddr[2] == ihc_pkg::REG_LOCAL_ADDRESS) ? local_address_ff : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         local_address_ff <= 32'd0;
      end else begin
         local_address_ff <= local_address_in;
      end
   end

   assign local_address = local_address_ff;

endmodule

// ===== rtl/ihc_in_stage.sv =====
// Input register for header byte beats.
module ihc_in_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   input  logic               advance,
   output logic               item_valid,
   output ihc_pkg::item_type  item
);

   logic              valid_ff;
   logic              valid_in;
   ihc_pkg::item_type item_ff;
   ihc_pkg::item_type item_in;
   logic              accept;

   assign req_tready = !valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.data_byte       = req_tdata;
         item_in.start_of_packet = req_tuser;
      end
      priority if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/ihc_core.sv =====
// Header parse state, running word sum and verdict logic.
module ihc_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  ihc_pkg::item_type   item,
   input  logic [31:0]         local_address,
   output ihc_pkg::result_type result
);

   logic [5:0]  pos_ff,        pos_in;
   logic [3:0]  hw_ff,         hw_in;
   logic [20:0] sum_ff,        sum_in;
   logic [7:0]  upper_ff,      upper_in;
   logic [15:0] csum_ff,       csum_in;
   logic        ttl_zero_ff,   ttl_zero_in;
   logic [31:0] dest_ff,       dest_in;
   logic        collecting_ff, collecting_in;

   logic [6:0]  pos_plus;
   logic [16:0] fold1;
   logic [15:0] fold2;
   logic [15:0] computed;
   logic [7:0]  b;

   always_comb begin
      pos_in        = pos_ff;
      hw_in         = hw_ff;
      sum_in        = sum_ff;
      upper_in      = upper_ff;
      csum_in       = csum_ff;
      ttl_zero_in   = ttl_zero_ff;
      dest_in       = dest_ff;
      collecting_in = collecting_ff;
      result.valid  = 1'b0;
      result.verdict = ihc_pkg::VERDICT_ACCEPT;
      b        = item.data_byte;
      pos_plus = {1'b0, pos_ff} + 7'd1;
      fold1    = 17'd0;
      fold2    = 16'd0;
      computed = 16'd0;
      if (fire) begin
         if (item.start_of_packet) begin
            collecting_in = 1'b0;
            sum_in        = 21'd0;
            csum_in       = 16'd0;
            ttl_zero_in   = 1'b0;
            dest_in       = 32'd0;
            priority if (b[7:4] != ihc_pkg::IP_VERSION) begin
               result.valid   = 1'b1;
               result.verdict = ihc_pkg::VERDICT_VERSION;
            end else if (b[3:0] < ihc_pkg::MIN_IHL) begin
               result.valid   = 1'b1;
               result.verdict = ihc_pkg::VERDICT_HEADER_LENGTH;
            end else begin
               hw_in         = b[3:0];
               upper_in      = b;
               pos_in        = 6'd1;
               collecting_in = 1'b1;
            end
         end else if (collecting_ff) begin
            if (!pos_ff[0]) begin
               upper_in = b;
            end else if (pos_ff[5:1] != ihc_pkg::CSUM_WORD) begin
               sum_in = sum_ff + {5'd0, upper_ff, b};
            end
            if (pos_ff == ihc_pkg::TTL_POS) begin
               ttl_zero_in = (b == 8'd0);
            end
            if (pos_ff == ihc_pkg::CSUM_HI_POS || pos_ff == ihc_pkg::CSUM_LO_POS) begin
               csum_in = {csum_ff[7:0], b};
            end
            if (pos_ff >= ihc_pkg::DEST_FIRST && pos_ff <= ihc_pkg::DEST_LAST) begin
               dest_in = {dest_ff[23:0], b};
            end
            pos_in = pos_plus[5:0];
            if (pos_plus >= {1'b0, hw_ff, 2'b00}) begin
               collecting_in = 1'b0;
               fold1 = {1'b0, sum_in[15:0]} + {12'd0, sum_in[20:16]};
               fold2 = fold1[15:0] + {15'd0, fold1[16]};
               computed = ~fold2;
               result.valid = 1'b1;
               priority if (ttl_zero_in) begin
                  result.verdict = ihc_pkg::VERDICT_TTL;
               end else if (computed != csum_in) begin
                  result.verdict = ihc_pkg::VERDICT_CHECKSUM;
               end else if (dest_in != local_address && dest_in != ihc_pkg::BROADCAST) begin
                  result.verdict = ihc_pkg::VERDICT_DESTINATION;
               end else begin
                  result.verdict = ihc_pkg::VERDICT_ACCEPT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 6'd0;
         hw_ff         <= 4'd0;
         sum_ff        <= 21'd0;
         upper_ff      <= 8'd0;
         csum_ff       <= 16'd0;
         ttl_zero_ff   <= 1'b0;
         dest_ff       <= 32'd0;
         collecting_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         hw_ff         <= hw_in;
         sum_ff        <= sum_in;
         upper_ff      <= upper_in;
         csum_ff       <= csum_in;
         ttl_zero_ff   <= ttl_zero_in;
         dest_ff       <= dest_in;
         collecting_ff <= collecting_in;
      end
   end

endmodule

// ===== rtl/ihc_out_stage.sv =====
// Result register driving the verdict stream.
module ihc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  ihc_pkg::result_type result,
   output logic                can_accept,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata
);

   logic                 valid_ff, valid_in;
   ihc_pkg::verdict_type verdict_ff, verdict_in;

   assign can_accept = !valid_ff || rsp_tready;

   always_comb begin
      valid_in   = valid_ff;
      verdict_in = verdict_ff;
      if (can_accept) begin
         valid_in = fire && result.valid;
      end
      if (fire && result.valid) begin
         verdict_in = result.verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {5'd0, verdict_ff};

endmodule

// ===== rtl/ipv4_header_check_unit.sv =====
// IPv4 receive header check: top level.
//
// Header bytes enter on the req_ stream, one byte per beat, most significant
// first; req_tuser marks the first byte of each packet. The first byte is
// checked for version 4 and IHL of at least 5, and a failure is reported at
// once. Otherwise 4*IHL bytes are gathered and one verdict is reported on the
// last header byte. Bytes after the verdict and before the next start mark
// give no beat; a new start mark mid-header drops the old header silently.
// The rsp_ stream carries the verdict code in rsp_tdata[2:0].
// A byte is held in the input register, and its verdict in the result register.
// Throughput: one byte per cycle unless rsp_tready stalls; the word add,
// end-around fold and compare lie between the input and result registers.
// The input register still takes one beat while a verdict waits on a stalled
// rsp_tready; every later byte then waits until the verdict is taken.
// Reset clears the parse state, the valid flags of both stream registers and local_address.
// local_address lies at csr_ byte address 0 and is to be written only when idle; the block does not enforce this.
module ipv4_header_check_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] start_of_packet
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [2:0] verdict, [7:3] zero
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]         local_address_w;
   logic                item_valid;
   ihc_pkg::item_type   item;
   ihc_pkg::result_type result;
   logic                can_accept;
   logic                fire;

   assign fire = item_valid && can_accept;

   ihc_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .local_address (local_address_w)
   );

   ihc_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (can_accept),
      .item_valid (item_valid),
      .item       (item)
   );

   ihc_core u_core (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .item          (item),
      .local_address (local_address_w),
      .result        (result)
   );

   ihc_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .result     (result),
      .can_accept (can_accept),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/ihc_checker.sv =====
// Port-level assertions for the IPv4 header check, bound to the top level.
module ihc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [2:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata,
   input logic        csr_pready
);

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low after reset");

   a_verdict_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:3] == 5'd0
                      && rsp_tdata[2:0] <= ihc_pkg::VERDICT_DESTINATION))
      else $error("verdict code out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled verdict beat changed");

   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      ($past(csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2])
       && !$past(reset) && !csr_paddr[2]) |-> csr_prdata == $past(csr_pwdata))
      else $error("local address readback mismatch");

endmodule

bind ipv4_header_check_unit ihc_checker u_ihc_checker (.*);

// ===== tb/tb.sv =====
// Testbench for ipv4_header_check_unit: byte stream in, verdict stream out, checked on the fly.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 1100;
   localparam int PHASES = 5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [2:0] LOCAL_ADDRESS_OFFSET = 3'(4 * ihc_pkg::REG_LOCAL_ADDRESS);

   typedef enum {CSUM_GOOD, CSUM_BAD, CSUM_NEG_ZERO} csum_mode_type;
   typedef enum {DEST_LOCAL, DEST_BCAST, DEST_OTHER} dest_mode_type;

   class verdict_scoreboard;
      logic [31:0] local_address;
      logic [5:0]  byte_pos;
      logic [3:0]  ihl_words;
      logic [20:0] word_sum;
      logic [7:0]  upper_byte;
      logic [15:0] stored_csum;
      logic        ttl_zero;
      logic [31:0] dest_word;
      logic        collecting;
      ihc_pkg::verdict_type expected_verdicts[$];
      int          errors;

      function new();
         local_address = '0;
         byte_pos = '0;
         ihl_words = '0;
         word_sum = '0;
         upper_byte = '0;
         stored_csum = '0;
         ttl_zero = 1'b0;
         dest_word = '0;
         collecting = 1'b0;
         errors = 0;
      endfunction

      function ihc_pkg::verdict_type header_verdict();
         logic [31:0] s;
         logic [15:0] c;
         s = 32'(word_sum);
         while (s[31:16] != 16'd0)
            s = 32'(s[15:0]) + 32'(s[31:16]);
         c = ~s[15:0];
         if (ttl_zero)
            return ihc_pkg::VERDICT_TTL;
         if (c != stored_csum)
            return ihc_pkg::VERDICT_CHECKSUM;
         if (dest_word != local_address && dest_word != ihc_pkg::BROADCAST)
            return ihc_pkg::VERDICT_DESTINATION;
         return ihc_pkg::VERDICT_ACCEPT;
      endfunction

      function void note_byte(logic [7:0] b, logic sop);
         int next_pos;
         if (sop) begin
            collecting = 1'b0;
            word_sum = '0;
            stored_csum = '0;
            ttl_zero = 1'b0;
            dest_word = '0;
            if (b[7:4] != ihc_pkg::IP_VERSION) begin
               expected_verdicts.push_back(ihc_pkg::VERDICT_VERSION);
               return;
            end
            if (b[3:0] < ihc_pkg::MIN_IHL) begin
               expected_verdicts.push_back(ihc_pkg::VERDICT_HEADER_LENGTH);
               return;
            end
            ihl_words = b[3:0];
            upper_byte = b;
            byte_pos = 6'd1;
            collecting = 1'b1;
            return;
         end
         if (!collecting)
            return;
         if (!byte_pos[0])
            upper_byte = b;
         else if (byte_pos[5:1] != ihc_pkg::CSUM_WORD)
            word_sum = word_sum + 21'({upper_byte, b});
         if (byte_pos == ihc_pkg::TTL_POS)
            ttl_zero = (b == 8'd0);
         if (byte_pos == ihc_pkg::CSUM_HI_POS || byte_pos == ihc_pkg::CSUM_LO_POS)
            stored_csum = {stored_csum[7:0], b};
         if (byte_pos >= ihc_pkg::DEST_FIRST && byte_pos <= ihc_pkg::DEST_LAST)
            dest_word = {dest_word[23:0], b};
         next_pos = int'(byte_pos) + 1;
         byte_pos = 6'(next_pos);
         if (next_pos >= 4 * int'(ihl_words)) begin
            collecting = 1'b0;
            expected_verdicts.push_back(header_verdict());
         end
      endfunction

      function void check_verdict(logic [7:0] beat);
         ihc_pkg::verdict_type want;
         if (expected_verdicts.size() == 0) begin
            $error("verdict: expected none, actual %0d", beat[2:0]);
            errors++;
            return;
         end
         want = expected_verdicts.pop_front();
         if (beat[2:0] !== want) begin
            $error("verdict: expected %0d, actual %0d", want, beat[2:0]);
            errors++;
         end
         if (beat[7:3] !== 5'd0) begin
            $error("rsp_tdata[7:3]: expected 0, actual %0h", beat[7:3]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // [7:0] data_byte
   logic        req_tuser = 1'b0; // [0] start_of_packet
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [2:0] verdict, [7:3] zero
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   verdict_scoreboard sb;
   logic [7:0] hdr_bytes [60];
   int counted_items = 0;
   int idle_pct = 30;
   int ready_pct = 70;
   int stall_left = 0;
   int cycle_count = 0;

   ipv4_header_check_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < ready_pct) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            stall_left <= $urandom_range(5, 40);
      end
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         sb.note_byte(req_tdata, req_tuser);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_verdict(rsp_tdata);
   end

   function automatic int pick_gap(int pct);
      if ($urandom_range(0, 99) >= pct)
         return 0;
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(8, 30);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [15:0] header_fold(int n);
      logic [31:0] s;
      s = '0;
      for (int i = 0; i < n; i += 2)
         if (i != 10)
            s = s + 32'({hdr_bytes[i], hdr_bytes[i + 1]});
      while (s[31:16] != 16'd0)
         s = 32'(s[15:0]) + 32'(s[31:16]);
      return s[15:0];
   endfunction

   function automatic void build_header(int ihl, bit ttl_is_zero, csum_mode_type cm,
                                        dest_mode_type dm, logic [31:0] host_addr);
      logic [31:0] dst;
      logic [15:0] f;
      logic [15:0] csum;
      int n;
      n = 4 * ihl;
      for (int i = 0; i < n; i++)
         hdr_bytes[i] = 8'($urandom_range(0, 255));
      hdr_bytes[0] = {ihc_pkg::IP_VERSION, 4'(ihl)};
      hdr_bytes[8] = ttl_is_zero ? 8'd0 : 8'($urandom_range(1, 255));
      case (dm)
         DEST_LOCAL: dst = host_addr;
         DEST_BCAST: dst = ihc_pkg::BROADCAST;
         default:    dst = $urandom;
      endcase
      {hdr_bytes[16], hdr_bytes[17], hdr_bytes[18], hdr_bytes[19]} = dst;
      if (cm == CSUM_NEG_ZERO) begin
         // force the folded sum to all ones so the computed checksum is zero
         hdr_bytes[4] = 8'd0;
         hdr_bytes[5] = 8'd0;
         {hdr_bytes[4], hdr_bytes[5]} = ~header_fold(n);
      end
      f = header_fold(n);
      case (cm)
         CSUM_GOOD: csum = ~f;
         CSUM_BAD:  csum = ~f ^ 16'($urandom_range(1, 65535));
         default:   csum = 16'hffff;
      endcase
      {hdr_bytes[10], hdr_bytes[11]} = csum;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic sop);
      int gap;
      gap = pick_gap(idle_pct);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= sop;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.local_address = value;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_random_packet(input logic [31:0] host_addr);
      int kind;
      int ihl;
      int n;
      int r;
      csum_mode_type cm;
      dest_mode_type dm;
      logic [7:0] b;
      kind = $urandom_range(0, 99);
      if (kind < 72) begin
         ihl = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5;
         r = $urandom_range(0, 19);
         cm = (r < 15) ? CSUM_GOOD : (r < 19) ? CSUM_BAD : CSUM_NEG_ZERO;
         r = $urandom_range(0, 9);
         dm = (r < 5) ? DEST_LOCAL : (r < 7) ? DEST_BCAST : DEST_OTHER;
         build_header(ihl, $urandom_range(0, 9) == 0, cm, dm, host_addr);
         n = 4 * ihl;
         if ($urandom_range(0, 11) == 0)
            n = $urandom_range(1, n - 1);
         for (int i = 0; i < n; i++)
            send_byte(hdr_bytes[i], i == 0);
         counted_items += n;
      end else if (kind < 80) begin
         do b = 8'($urandom); while (b[7:4] == ihc_pkg::IP_VERSION);
         send_byte(b, 1'b1);
         counted_items++;
      end else if (kind < 88) begin
         send_byte({ihc_pkg::IP_VERSION, 4'($urandom_range(0, 4))}, 1'b1);
         counted_items++;
      end else begin
         n = $urandom_range(1, 6);
         repeat (n) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
         counted_items += n;
      end
      if ($urandom_range(0, 9) == 0) begin
         n = $urandom_range(1, 4);
         repeat (n) send_byte(8'($urandom), 1'b0);
         counted_items += n;
      end
   endtask

   initial begin
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'ha5, 1'b0);
      send_byte(8'h34, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'h44, 1'b1);
      send_byte(8'h40, 1'b1);
      send_byte(8'h4f, 1'b1);
      send_byte(8'h12, 1'b0);
      build_header(5, 1'b0, CSUM_GOOD, DEST_LOCAL, 32'h0);
      for (int i = 0; i < 20; i++)
         send_byte(hdr_bytes[i], i == 0);

      for (int p = 0; p < PHASES; p++) begin
         // close any open header before touching the register
         send_byte(8'h00, 1'b1);
         drain();
         case (p)
            0:       csr_write(LOCAL_ADDRESS_OFFSET, 32'h0000_0000);
            1:       csr_write(LOCAL_ADDRESS_OFFSET, 32'hffff_ffff);
            default: csr_write(LOCAL_ADDRESS_OFFSET, $urandom);
         endcase
         if (p == 2) begin
            idle_pct = 0;
            ready_pct = 100;
         end else begin
            idle_pct = $urandom_range(10, 50);
            ready_pct = $urandom_range(50, 90);
         end
         while (counted_items < (p + 1) * ITEM_TARGET / PHASES)
            send_random_packet(sb.local_address);
      end

      drain();
      if (sb.errors == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
